// ----- rtl/log_range_index_table_assert.svh -----
// Assertion macros used by the checker module of the range index table.
`ifndef LOG_RANGE_INDEX_TABLE_ASSERT_SVH
`define LOG_RANGE_INDEX_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LRIT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LRIT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/lrit_pkg.sv -----
// Shared types and codes of the log range index table.
package lrit_pkg;

	// operation codes on the input port
	localparam logic [2:0] OP_UPDATE  = 3'd0;
	localparam logic [2:0] OP_RAISE   = 3'd1;
	localparam logic [2:0] OP_QUERY   = 3'd2;
	localparam logic [2:0] OP_INUSE   = 3'd3;
	localparam logic [2:0] OP_COMPACT = 3'd4;
	localparam logic [2:0] OP_REMOVE  = 3'd5;

	// result status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_RANGE   = 3'd1;
	localparam logic [2:0] ST_KIND    = 3'd2;
	localparam logic [2:0] ST_NOTHING = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;

	localparam logic [1:0] KIND_NORMAL = 2'd0;

	// longest run of results for one query or removal
	localparam int MAX_RUN = 64;

	typedef enum logic [2:0] {
		CMD_UPDATE,
		CMD_RAISE,
		CMD_QUERY,
		CMD_INUSE,
		CMD_COMPACT,
		CMD_REMOVE,
		CMD_NONE
	} cmd_t;

	// classified item: key is the index or limit the command works on,
	// aux the second index (last index of an update, high end of a query)
	typedef struct packed {
		cmd_t        cmd;
		logic [63:0] key;
		logic [63:0] aux;
		logic [63:0] file;
		logic [31:0] offset;
		logic [31:0] length;
		logic [1:0]  kind;
	} item_t;

	typedef struct packed {
		logic [63:0] first_idx;
		logic [63:0] last_idx;
		logic [63:0] file;
		logic [31:0] offset;
		logic [31:0] length;
		logic [1:0]  kind;
	} entry_t;

	typedef struct packed {
		logic [2:0]  status;
		entry_t      ent;
		logic        in_use;
		logic [63:0] max_obs;
		logic        last;
	} result_t;

endpackage

// ----- rtl/lrit_front.sv -----
// Front end: accepts input items, classifies them and hands them to the queue.
module lrit_front import lrit_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [63:0] head_index,
	input  logic [63:0] tail_index,
	input  logic [63:0] file_id,
	input  logic [31:0] file_offset,
	input  logic [31:0] entry_length,
	input  logic [1:0]  entry_kind,
	input  logic [63:0] range_low,
	input  logic [63:0] range_high,
	input  logic [63:0] compact_to,
	input  logic [63:0] remove_limit,
	output logic        push,
	output item_t       push_item,
	input  logic        push_ready
);

	item_t item_d;
	item_t item_s1;
	logic  valid_s1;

	// classify: pick the command and the key fields it works on
	always_comb begin
		item_d        = '0;
		item_d.file   = file_id;
		item_d.offset = file_offset;
		item_d.length = entry_length;
		item_d.kind   = entry_kind;
		case (operation)
			OP_UPDATE: begin
				item_d.cmd = CMD_UPDATE;
				item_d.key = head_index;
				item_d.aux = tail_index;
			end
			OP_RAISE: begin
				item_d.cmd = CMD_RAISE;
				item_d.key = compact_to;
			end
			OP_QUERY: begin
				item_d.cmd = CMD_QUERY;
				item_d.key = range_low;
				item_d.aux = range_high;
			end
			OP_INUSE:   item_d.cmd = CMD_INUSE;
			OP_COMPACT: item_d.cmd = CMD_COMPACT;
			OP_REMOVE: begin
				item_d.cmd = CMD_REMOVE;
				item_d.key = remove_limit;
			end
			default:    item_d.cmd = CMD_NONE;
		endcase
	end

	assign in_ready  = !valid_s1 || push_ready;
	assign push      = valid_s1;
	assign push_item = item_s1;

	// hold one classified item until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_d;
		end
	end

endmodule

// ----- rtl/lrit_queue.sv -----
// Two-entry queue of classified items between front end and engine.
module lrit_queue import lrit_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  push_ready,
	output logic  pop_valid,
	output item_t pop_item,
	input  logic  pop
);

	item_t      slots_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_item   = slots_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop) fill_q <= fill_q + 2'd1;
			else if (do_pop && !do_push) fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- rtl/lrit_engine.sv -----
// Back end: entry memory, compacted mark and the sequencer that runs each command.
module lrit_engine import lrit_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_valid,
	input  item_t   q_item,
	output logic    q_pop,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_RD, S_ULAST, S_UWRITE, S_S0, S_STEP, S_PROBE, S_FIN,
		S_QNEXT, S_QUSE, S_WCHK, S_WUSE, S_CFIRST, S_CCHK, S_CUSE,
		S_RCHK, S_RUSE, S_RDONE, S_EMIT
	} state_t;

	entry_t      mem_q [DEPTH];
	entry_t      rd_q;
	state_t      state_q;
	state_t      nxt_q;
	item_t       item_q;
	result_t     out_q;
	logic        out_valid_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] base_q;
	logic [63:0] mark_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi_q;
	logic [CW:0]   slot_q;
	logic        s0ok_q;
	entry_t      cur_q;
	logic [6:0]  run_q;
	logic [63:0] prev_file_q;
	logic [63:0] prev_end_q;
	logic [63:0] best_q;
	logic        pend_q;
	logic [63:0] pend_file_q;
	logic [2:0]  st_q;
	logic        iu_q;
	logic [63:0] mo_q;

	logic          out_free;
	logic          emit_w;
	logic          more_w;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	entry_t        wr_data;
	logic [CW-1:0] mid_w;
	logic          hit_w;
	logic [CW:0]   slot_w;
	logic [CW:0]   ptr_nx1;
	logic          cont_w;
	entry_t        new_ent;
	entry_t        trunc_ent;

	// logical index to memory row, relative to the head of the table
	function automatic logic [IW-1:0] phys(input logic [IW-1:0] b, input logic [CW-1:0] p);
		logic [IW:0] s;
		s = (IW+1)'(b) + (IW+1)'(p);
		if (s >= (IW+1)'(DEPTH)) s = s - (IW+1)'(DEPTH);
		return s[IW-1:0];
	endfunction

	function automatic result_t mk_res(input logic [2:0] st, input entry_t e,
		input logic iu, input logic [63:0] mo, input logic lst);
		result_t r;
		r.status  = st;
		r.ent     = e;
		r.in_use  = iu;
		r.max_obs = mo;
		r.last    = lst;
		return r;
	endfunction

	// entry that carries only a file id, for removal results
	function automatic entry_t file_ent(input logic [63:0] f);
		entry_t e;
		e      = '0;
		e.file = f;
		return e;
	endfunction

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign q_pop     = (state_q == S_IDLE) && q_valid;

	assign rd_addr = phys(base_q, ptr_q);
	assign mid_w   = lo_q + ((hi_q - lo_q) >> 1);
	assign hit_w   = (rd_q.first_idx <= item_q.key) && (rd_q.last_idx >= item_q.key);
	assign slot_w  = (rd_q.first_idx == item_q.key) ? {1'b0, ptr_q} : {1'b0, ptr_q} + 1'b1;
	assign ptr_nx1 = {1'b0, ptr_q} + 1'b1;
	assign more_w  = (ptr_nx1 < {1'b0, count_q}) && (run_q < 7'(MAX_RUN));
	assign cont_w  = (item_q.aux >= rd_q.first_idx) &&
		(cur_q.last_idx + 64'd1 == rd_q.first_idx);

	always_comb begin
		new_ent.first_idx = item_q.key;
		new_ent.last_idx  = item_q.aux;
		new_ent.file      = item_q.file;
		new_ent.offset    = item_q.offset;
		new_ent.length    = item_q.length;
		new_ent.kind      = item_q.kind;
		trunc_ent          = rd_q;
		trunc_ent.last_idx = item_q.key - 64'd1;
	end

	// result register load: one transfer leaves the sequencer
	always_comb begin
		case (state_q)
			S_QNEXT: emit_w = !more_w && out_free;
			S_QUSE:  emit_w = out_free;
			S_RUSE:  emit_w = (rd_q.file <= item_q.key) && pend_q && out_free;
			S_RDONE: emit_w = pend_q && out_free;
			S_EMIT:  emit_w = out_free;
			default: emit_w = 1'b0;
		endcase
	end

	// memory write: truncate the covering entry, or place the new one
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = phys(base_q, ptr_q);
		wr_data = trunc_ent;
		if (state_q == S_FIN && item_q.cmd == CMD_UPDATE && hit_w &&
			slot_w < (CW+1)'(DEPTH) && slot_w != {1'b0, ptr_q}) begin
			wr_en = 1'b1;
		end else if (state_q == S_UWRITE) begin
			wr_en   = 1'b1;
			wr_addr = phys(base_q, slot_q[CW-1:0]);
			wr_data = new_ent;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_q <= mem_q[rd_addr];
	end

	// sequencer with registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nxt_q       <= S_IDLE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			base_q      <= '0;
			mark_q      <= '0;
			ptr_q       <= '0;
			pend_q      <= 1'b0;
		end else begin
			out_valid_q <= emit_w || (out_valid_q && !out_ready);
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						item_q  <= q_item;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					iu_q   <= 1'b0;
					pend_q <= 1'b0;
					ptr_q  <= (item_q.cmd == CMD_UPDATE) ? count_q - 1'b1 : '0;
					st_q   <= (item_q.cmd == CMD_NONE || (item_q.cmd == CMD_QUERY &&
						(item_q.key <= mark_q || count_q == '0))) ? ST_NOTHING : ST_OK;
					mo_q   <= (item_q.cmd == CMD_COMPACT && count_q == '0) ?
						64'hFFFF_FFFF_FFFF_FFFF : 64'd0;
					case (item_q.cmd)
						CMD_UPDATE: begin
							if (count_q == '0) begin
								slot_q  <= '0;
								state_q <= S_UWRITE;
							end else begin
								nxt_q   <= S_ULAST;
								state_q <= S_RD;
							end
						end
						CMD_RAISE: begin
							if (item_q.key > mark_q) mark_q <= item_q.key;
							state_q <= S_EMIT;
						end
						CMD_QUERY: begin
							if (item_q.key <= mark_q || count_q == '0) begin
								state_q <= S_EMIT;
							end else begin
								nxt_q   <= S_S0;
								state_q <= S_RD;
							end
						end
						CMD_INUSE: state_q <= S_WCHK;
						CMD_COMPACT: begin
							if (count_q == '0) begin
								state_q <= S_EMIT;
							end else begin
								nxt_q   <= S_CFIRST;
								state_q <= S_RD;
							end
						end
						CMD_REMOVE: state_q <= S_RCHK;
						default: state_q <= S_EMIT;
					endcase
				end
				// wait state for the registered memory read
				S_RD: state_q <= nxt_q;
				S_ULAST: begin
					if (item_q.key == rd_q.last_idx + 64'd1) begin
						if (count_q == CW'(DEPTH)) begin
							st_q    <= ST_FULL;
							state_q <= S_EMIT;
						end else begin
							slot_q  <= {1'b0, count_q};
							state_q <= S_UWRITE;
						end
					end else begin
						ptr_q   <= '0;
						nxt_q   <= S_S0;
						state_q <= S_RD;
					end
				end
				S_UWRITE: begin
					count_q <= slot_q[CW-1:0] + 1'b1;
					state_q <= S_EMIT;
				end
				// binary search for the entry holding the key
				S_S0: begin
					s0ok_q  <= (rd_q.first_idx <= item_q.key);
					lo_q    <= '0;
					hi_q    <= count_q - 1'b1;
					state_q <= S_STEP;
				end
				S_STEP: begin
					if (lo_q < hi_q) begin
						ptr_q <= mid_w;
						nxt_q <= S_PROBE;
					end else begin
						ptr_q <= lo_q;
						nxt_q <= S_FIN;
					end
					state_q <= S_RD;
				end
				S_PROBE: begin
					if (s0ok_q && rd_q.last_idx >= item_q.key) hi_q <= ptr_q;
					else lo_q <= ptr_q + 1'b1;
					state_q <= S_STEP;
				end
				S_FIN: begin
					if (!hit_w) begin
						st_q    <= (item_q.cmd == CMD_UPDATE) ? ST_RANGE : ST_NOTHING;
						state_q <= S_EMIT;
					end else if (item_q.cmd == CMD_UPDATE) begin
						if (slot_w >= (CW+1)'(DEPTH)) begin
							st_q    <= ST_FULL;
							state_q <= S_EMIT;
						end else begin
							slot_q  <= slot_w;
							state_q <= S_UWRITE;
						end
					end else begin
						cur_q   <= rd_q;
						run_q   <= 7'd1;
						state_q <= S_QNEXT;
					end
				end
				// query run: look one entry ahead to mark the last result
				S_QNEXT: begin
					if (more_w) begin
						ptr_q   <= ptr_nx1[CW-1:0];
						nxt_q   <= S_QUSE;
						state_q <= S_RD;
					end else if (out_free) begin
						out_q   <= mk_res(ST_OK, cur_q, 1'b0, '0, 1'b1);
						state_q <= S_IDLE;
					end
				end
				S_QUSE: begin
					if (out_free) begin
						out_q <= mk_res(ST_OK, cur_q, 1'b0, '0, !cont_w);
						if (cont_w) begin
							cur_q   <= rd_q;
							run_q   <= run_q + 7'd1;
							state_q <= S_QNEXT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				// file in use: walk from the front
				S_WCHK: begin
					if (ptr_q >= count_q) begin
						state_q <= S_EMIT;
					end else begin
						nxt_q   <= S_WUSE;
						state_q <= S_RD;
					end
				end
				S_WUSE: begin
					if (rd_q.file == item_q.file) begin
						iu_q    <= 1'b1;
						state_q <= S_EMIT;
					end else if (rd_q.file > item_q.file) begin
						state_q <= S_EMIT;
					end else begin
						ptr_q   <= ptr_q + 1'b1;
						state_q <= S_WCHK;
					end
				end
				// compaction: track file changes and the highest obsolete id
				S_CFIRST: begin
					prev_file_q <= rd_q.file;
					prev_end_q  <= rd_q.last_idx;
					best_q      <= rd_q.file - 64'd1;
					ptr_q       <= CW'(1);
					state_q     <= S_CCHK;
				end
				S_CCHK: begin
					if (ptr_q >= count_q) begin
						mo_q    <= best_q;
						state_q <= S_EMIT;
					end else begin
						nxt_q   <= S_CUSE;
						state_q <= S_RD;
					end
				end
				S_CUSE: begin
					if (rd_q.kind != KIND_NORMAL) begin
						st_q    <= ST_KIND;
						state_q <= S_EMIT;
					end else begin
						if (rd_q.file != prev_file_q) begin
							if (prev_end_q <= mark_q) best_q <= prev_file_q;
							prev_file_q <= rd_q.file;
						end
						prev_end_q <= rd_q.last_idx;
						ptr_q      <= ptr_q + 1'b1;
						state_q    <= S_CCHK;
					end
				end
				// removal: emit each dropped file id, one behind the scan
				S_RCHK: begin
					if (ptr_q < count_q && 32'(ptr_q) < MAX_RUN) begin
						nxt_q   <= S_RUSE;
						state_q <= S_RD;
					end else begin
						state_q <= S_RDONE;
					end
				end
				S_RUSE: begin
					if (rd_q.file > item_q.key) begin
						state_q <= S_RDONE;
					end else if (!pend_q || out_free) begin
						if (pend_q) begin
							out_q <= mk_res(ST_OK, file_ent(pend_file_q), 1'b0, '0, 1'b0);
						end
						pend_q      <= 1'b1;
						pend_file_q <= rd_q.file;
						ptr_q       <= ptr_q + 1'b1;
						state_q     <= S_RCHK;
					end
				end
				S_RDONE: begin
					if (!pend_q) begin
						st_q    <= ST_NOTHING;
						state_q <= S_EMIT;
					end else if (out_free) begin
						out_q   <= mk_res(ST_OK, file_ent(pend_file_q), 1'b0, '0, 1'b1);
						base_q  <= phys(base_q, ptr_q);
						count_q <= count_q - ptr_q;
						pend_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_q   <= mk_res(st_q, '0, iu_q, mo_q, 1'b1);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/log_range_index_table.sv -----
// Top level of the log range index table: front end, item queue and engine.
//
// Keeps an ordered table of up to TABLE_DEPTH log index ranges plus a rising
// compacted mark. Items go through a classifying front end and a two-entry
// queue, so input is taken while the engine works or a result waits. The
// engine reads its entry memory through one port with a registered read, so
// each entry visited takes an issue, a read and a use step: an update or query
// locates its entry by binary search unless an update appends after the last
// entry, and a query run, a file-in-use walk, a compaction scan or a removal
// visits each entry it touches in turn. A stalled receiver holds back each
// result until it is taken. Removal moves a head pointer instead of shifting
// rows. No clearing pass is needed after reset.
module log_range_index_table import lrit_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [63:0] head_index,
	input  logic [63:0] tail_index,
	input  logic [63:0] file_id,
	input  logic [31:0] file_offset,
	input  logic [31:0] entry_length,
	input  logic [1:0]  entry_kind,
	input  logic [63:0] range_low,
	input  logic [63:0] range_high,
	input  logic [63:0] compact_to,
	input  logic [63:0] remove_limit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [63:0] out_head_index,
	output logic [63:0] out_tail_index,
	output logic [63:0] out_file_id,
	output logic [31:0] out_offset,
	output logic [31:0] out_length,
	output logic [1:0]  out_kind,
	output logic        in_use,
	output logic [63:0] obsolete_id,
	output logic        last_of_run
);

	logic    push;
	item_t   push_item;
	logic    push_ready;
	logic    q_valid;
	item_t   q_item;
	logic    q_pop;
	result_t res;

	lrit_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .operation, .head_index, .tail_index,
		.file_id, .file_offset, .entry_length, .entry_kind, .range_low, .range_high,
		.compact_to, .remove_limit, .push, .push_item, .push_ready
	);

	lrit_queue u_queue (
		.clk, .arst_n, .push, .push_item, .push_ready,
		.pop_valid(q_valid), .pop_item(q_item), .pop(q_pop)
	);

	lrit_engine #(.DEPTH(TABLE_DEPTH)) u_engine (
		.clk, .arst_n, .q_valid, .q_item, .q_pop,
		.out_valid, .out_ready, .out_res(res)
	);

	// unpack the registered result onto the field ports
	assign status         = res.status;
	assign out_head_index = res.ent.first_idx;
	assign out_tail_index = res.ent.last_idx;
	assign out_file_id    = res.ent.file;
	assign out_offset     = res.ent.offset;
	assign out_length     = res.ent.length;
	assign out_kind       = res.ent.kind;
	assign in_use         = res.in_use;
	assign obsolete_id    = res.max_obs;
	assign last_of_run    = res.last;

endmodule

// ----- rtl/lrit_checker.sv -----
// Port-level checker for the log range index table, bound to the top level.
`include "log_range_index_table_assert.svh"
module lrit_checker import lrit_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic        in_use,
	input logic [63:0] obsolete_id,
	input logic        last_of_run
);

	// a stalled result stays on the port
	`LRIT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(last_of_run), "stalled result changed")
	// error and empty results always close their item
	`LRIT_ASSERT_IMPL(a_err_single, out_valid && status != ST_OK, last_of_run, "error result not final")
	// a file hit is a lone successful result
	`LRIT_ASSERT_IMPL(a_inuse_ok, out_valid && in_use, status == ST_OK && last_of_run, "bad file hit result")
	// a bad kind during compaction reports no obsolete id
	`LRIT_ASSERT_IMPL(a_kind_zero, out_valid && status == ST_KIND, obsolete_id == 64'd0, "bad kind with obsolete id")

endmodule

bind log_range_index_table lrit_checker u_lrit_checker (.*);
